FILE: hdl/rrg_pkg.sv
// Package for the fraction reducer: data width and the request and response
// payload types. Depends on nothing; used by rational_reduce_gcd, its checker and its testbench.
package rrg_pkg;

    localparam int DATA_W = 32;
    localparam int MAG_W  = DATA_W - 1;

    typedef struct packed {
        logic signed [DATA_W-1:0] num_in;
        logic signed [DATA_W-1:0] den_in;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] num_out;
        logic [MAG_W-1:0]         den_out;
    } rsp_t;

endpackage

FILE: hdl/rational_reduce_gcd.sv
// Fraction reducer top level: sequencer plus one shared restoring divider.
// Depends on rrg_pkg for the data width and the payload structs.

// Reduces a signed fraction to lowest terms, with the sign on the numerator
// and a non-negative denominator. A zero numerator gives 0/1, and a zero
// denominator with a nonzero numerator gives +1/0 or -1/0. The most negative
// input value is saturated to one above it. One restoring divider, one
// quotient bit per cycle, does all the work. Each Euclid remainder step
// loads the divider and then develops all MAG_W quotient bits. One more
// load then starts the two final divisions of the numerator and the
// denominator by the GCD, and the output register is loaded last. The
// number of Euclid steps is at most about 45 for 31-bit magnitudes.
// A zero numerator skips the divider and goes straight to the output load.
// The block takes no new transfer until the result has been loaded into the
// output register; that register holds the result while the consumer stalls,
// and while an older result is stalled, the load of the next one waits.
module rational_reduce_gcd (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rrg_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rrg_pkg::rsp_t rsp
);

    localparam int W  = rrg_pkg::DATA_W;
    localparam int MW = rrg_pkg::MAG_W;
    localparam int CW = $clog2(MW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EUC,
        S_EDIV,
        S_NDIV,
        S_DDIV,
        S_OUT
    } state_t;

    state_t         state_reg;
    logic [MW-1:0]  nm_reg;
    logic [MW-1:0]  dm_reg;
    logic           nneg_reg;
    logic           dneg_reg;
    logic [MW-1:0]  x_reg;
    logic [MW-1:0]  y_reg;
    logic [MW-1:0]  dq_reg;
    logic [MW-1:0]  dr_reg;
    logic [MW-1:0]  dd_reg;
    logic [CW-1:0]  cnt_reg;
    logic           rsp_valid_reg;
    rrg_pkg::rsp_t  rsp_reg;

    logic [W-1:0]   num_raw;
    logic [W-1:0]   den_raw;
    logic [MW-1:0]  num_negated;
    logic [MW-1:0]  den_negated;
    logic [MW-1:0]  num_mag;
    logic [MW-1:0]  den_mag;
    logic [MW:0]    rem_shift;
    logic [MW:0]    rem_sub;
    logic           rem_ge;
    logic [MW-1:0]  dr_next;
    logic [MW-1:0]  dq_next;
    logic           div_last;
    logic           out_free;
    logic           res_neg;
    logic [W-1:0]   res_num;

    // Sign and saturated magnitude of each input field.
    always_comb
    begin
        num_raw     = req.num_in;
        den_raw     = req.den_in;
        num_negated = MW'(0) - num_raw[MW-1:0];
        den_negated = MW'(0) - den_raw[MW-1:0];
        if (!num_raw[W-1])
            num_mag = num_raw[MW-1:0];
        else if (num_raw == {1'b1, {MW{1'b0}}})
            num_mag = {MW{1'b1}};
        else
            num_mag = num_negated;
        if (!den_raw[W-1])
            den_mag = den_raw[MW-1:0];
        else if (den_raw == {1'b1, {MW{1'b0}}})
            den_mag = {MW{1'b1}};
        else
            den_mag = den_negated;
    end

    // One step of the restoring divider: shift in the next dividend bit and
    // subtract the divisor when it fits. The partial remainder stays below
    // twice the divisor, so the top bit of the difference is the borrow.
    always_comb
    begin
        rem_shift = {dr_reg, dq_reg[MW-1]};
        rem_sub   = rem_shift - {1'b0, dd_reg};
        rem_ge    = !rem_sub[MW];
        dr_next   = rem_ge ? rem_sub[MW-1:0] : rem_shift[MW-1:0];
        dq_next   = {dq_reg[MW-2:0], rem_ge};
        div_last  = (cnt_reg == CW'(0));
    end

    // A zero denominator is never negative, so the sign follows the numerator.
    always_comb
    begin
        res_neg = (dm_reg != MW'(0)) ? (nneg_reg ^ dneg_reg) : nneg_reg;
        res_num = res_neg ? (W'(0) - {1'b0, nm_reg}) : {1'b0, nm_reg};
    end

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
            nm_reg        <= '0;
            dm_reg        <= '0;
            nneg_reg      <= 1'b0;
            dneg_reg      <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            dq_reg        <= '0;
            dr_reg        <= '0;
            dd_reg        <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            if (state_reg == S_OUT && out_free)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        nneg_reg <= num_raw[W-1];
                        dneg_reg <= den_raw[W-1];
                        x_reg    <= num_mag;
                        y_reg    <= den_mag;
                        if (num_mag == MW'(0))
                        begin
                            nm_reg    <= MW'(0);
                            dm_reg    <= MW'(1);
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            nm_reg    <= num_mag;
                            dm_reg    <= den_mag;
                            state_reg <= S_EUC;
                        end
                    end
                end

                S_EUC:
                begin
                    dr_reg  <= MW'(0);
                    dd_reg  <= (y_reg == MW'(0)) ? x_reg : y_reg;
                    dq_reg  <= (y_reg == MW'(0)) ? nm_reg : x_reg;
                    cnt_reg <= CW'(MW - 1);
                    // When the remainder reaches zero, x holds the GCD.
                    state_reg <= (y_reg == MW'(0)) ? S_NDIV : S_EDIV;
                end

                S_EDIV:
                begin
                    dq_reg  <= dq_next;
                    dr_reg  <= dr_next;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (div_last)
                    begin
                        x_reg     <= y_reg;
                        y_reg     <= dr_next;
                        state_reg <= S_EUC;
                    end
                end

                S_NDIV:
                begin
                    if (div_last)
                    begin
                        nm_reg    <= dq_next;
                        dq_reg    <= dm_reg;
                        dr_reg    <= MW'(0);
                        cnt_reg   <= CW'(MW - 1);
                        state_reg <= S_DDIV;
                    end
                    else
                    begin
                        dq_reg  <= dq_next;
                        dr_reg  <= dr_next;
                        cnt_reg <= cnt_reg - CW'(1);
                    end
                end

                S_DDIV:
                begin
                    dq_reg  <= dq_next;
                    dr_reg  <= dr_next;
                    cnt_reg <= cnt_reg - CW'(1);
                    if (div_last)
                    begin
                        dm_reg    <= dq_next;
                        state_reg <= S_OUT;
                    end
                end

                S_OUT:
                begin
                    if (out_free)
                    begin
                        rsp_reg.num_out <= res_num;
                        rsp_reg.den_out <= dm_reg;
                        state_reg       <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: tb/rational_reduce_gcd_checker.sv
// Checker for the fraction reducer: watches both channels, predicts each reduced
// fraction and compares it with the transfer that comes out. Depends on rrg_pkg.
module rational_reduce_gcd_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  logic          req_stall,
    input  rrg_pkg::req_t req,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  rrg_pkg::rsp_t rsp,
    output int            errors,
    output int            pending
);

    rrg_pkg::rsp_t reduced_q[$];

    // The most negative value saturates, so every magnitude fits in MAG_W bits.
    function automatic logic [rrg_pkg::MAG_W-1:0] magnitude(
        logic [rrg_pkg::DATA_W-1:0] v);
        logic [rrg_pkg::DATA_W-1:0] m;
        m = v[rrg_pkg::DATA_W-1] ? -v : v;
        return m[rrg_pkg::DATA_W-1] ? {rrg_pkg::MAG_W{1'b1}} : m[rrg_pkg::MAG_W-1:0];
    endfunction

    function automatic rrg_pkg::rsp_t reduce_fraction(rrg_pkg::req_t item);
        logic [rrg_pkg::MAG_W-1:0]  n_mag;
        logic [rrg_pkg::MAG_W-1:0]  d_mag;
        logic [rrg_pkg::MAG_W-1:0]  x;
        logic [rrg_pkg::MAG_W-1:0]  y;
        logic [rrg_pkg::MAG_W-1:0]  r;
        logic [rrg_pkg::DATA_W-1:0] wide;
        logic                       n_neg;
        logic                       d_neg;
        logic                       neg;
        rrg_pkg::rsp_t              res;
        n_neg = item.num_in[rrg_pkg::DATA_W-1];
        d_neg = item.den_in[rrg_pkg::DATA_W-1];
        n_mag = magnitude(item.num_in);
        d_mag = magnitude(item.den_in);
        if (n_mag == '0)
        begin
            res.num_out = '0;
            res.den_out = rrg_pkg::MAG_W'(1);
            return res;
        end
        x = n_mag;
        y = d_mag;
        while (y != '0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        n_mag = n_mag / x;
        d_mag = d_mag / x;
        // A zero denominator has no sign, so the numerator keeps its own.
        neg = (d_mag != '0) ? (n_neg ^ d_neg) : n_neg;
        wide = {1'b0, n_mag};
        res.num_out = neg ? -wide : wide;
        res.den_out = d_mag;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rrg_pkg::rsp_t want;
        if (!rst_n)
        begin
            reduced_q.delete();
            errors  = 0;
            pending = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (reduced_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result %0d/%0d", rsp.num_out, rsp.den_out);
                    errors++;
                end
                else
                begin
                    want = reduced_q.pop_front();
                    if (rsp.num_out !== want.num_out || rsp.den_out !== want.den_out)
                    begin
                        if (errors < 10)
                            $display("mismatch: expected %0d/%0d, got %0d/%0d",
                                     want.num_out, want.den_out,
                                     rsp.num_out, rsp.den_out);
                        errors++;
                    end
                end
            end
            if (req_valid && !req_stall)
                reduced_q.push_back(reduce_fraction(req));
            pending = reduced_q.size();
        end
    end

endmodule

FILE: tb/rational_reduce_gcd_tb.sv
// Testbench top for the fraction reducer: clock, reset, stimulus and verdict.
// Depends on rrg_pkg, rational_reduce_gcd and rational_reduce_gcd_checker.
module rational_reduce_gcd_tb;

    localparam int RANDOM_ITEMS = 1900;
    localparam int SETTLE_CYCLES = 1600;
    localparam logic [rrg_pkg::DATA_W-1:0] MOST_NEG = {1'b1, {rrg_pkg::MAG_W{1'b0}}};
    localparam logic [rrg_pkg::DATA_W-1:0] MOST_POS = {1'b0, {rrg_pkg::MAG_W{1'b1}}};

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    rrg_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_stall;
    rrg_pkg::rsp_t rsp;
    int            errors;
    int            pending;
    bit            calm;

    rational_reduce_gcd u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    rational_reduce_gcd_checker u_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("rational_reduce_gcd_tb: done, errors");
        $finish;
    end

    function automatic logic [rrg_pkg::DATA_W-1:0] signed_word(int unsigned mag, bit neg);
        logic [rrg_pkg::DATA_W-1:0] v;
        v = mag;
        return neg ? -v : v;
    endfunction

    function automatic rrg_pkg::req_t fraction(logic [rrg_pkg::DATA_W-1:0] n,
                                               logic [rrg_pkg::DATA_W-1:0] d);
        rrg_pkg::req_t item;
        item.num_in = n;
        item.den_in = d;
        return item;
    endfunction

    // Consecutive Fibonacci numbers are the slowest case for Euclid.
    function automatic rrg_pkg::req_t fib_pair(int idx);
        int unsigned a;
        int unsigned b;
        int unsigned t;
        a = 0;
        b = 1;
        for (int i = 0; i < idx; i++)
        begin
            t = a + b;
            a = b;
            b = t;
        end
        if ($urandom_range(0, 1))
            return fraction(signed_word(b, $urandom_range(0, 1)),
                            signed_word(a, $urandom_range(0, 1)));
        return fraction(signed_word(a, $urandom_range(0, 1)),
                        signed_word(b, $urandom_range(0, 1)));
    endfunction

    function automatic rrg_pkg::req_t draw_fraction();
        int unsigned pick;
        int unsigned kb;
        int unsigned k;
        int unsigned a;
        int unsigned b;
        logic [rrg_pkg::DATA_W-1:0] edges[5];
        edges = '{MOST_NEG, MOST_POS, MOST_NEG + 1, 1, '1};
        pick = $urandom_range(0, 99);
        if (pick < 35)
        begin
            // Shared factor k, so the reduction removes something whenever k exceeds one.
            kb = $urandom_range(1, 16);
            k  = $urandom & ((32'd1 << kb) - 1);
            if (k == 0)
                k = 1;
            a = $urandom & ((32'd1 << (31 - kb)) - 1);
            b = $urandom & ((32'd1 << (31 - kb)) - 1);
            return fraction(signed_word(a * k, $urandom_range(0, 1)),
                            signed_word(b * k, $urandom_range(0, 1)));
        end
        if (pick < 55)
            return fraction($urandom, $urandom);
        if (pick < 75)
            return fraction(signed_word($urandom_range(0, 300), $urandom_range(0, 1)),
                            signed_word($urandom_range(0, 300), $urandom_range(0, 1)));
        if (pick < 83)
        begin
            if ($urandom_range(0, 1))
                return fraction('0, $urandom);
            return fraction($urandom, '0);
        end
        if (pick < 88)
            return fib_pair($urandom_range(20, 46));
        if (pick < 93)
        begin
            a = $urandom_range(1, 65535);
            k = $urandom_range(1, 32767);
            if ($urandom_range(0, 1))
                return fraction(signed_word(a * k, $urandom_range(0, 1)),
                                signed_word(a, $urandom_range(0, 1)));
            return fraction(signed_word(a, $urandom_range(0, 1)),
                            signed_word(a * k, $urandom_range(0, 1)));
        end
        if ($urandom_range(0, 1))
            return fraction(edges[$urandom_range(0, 4)], $urandom);
        return fraction($urandom, edges[$urandom_range(0, 4)]);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send(input rrg_pkg::req_t item);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 15);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
    endtask

    // Result side: a fresh stall length for every transfer.
    initial
    begin
        int hold;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            hold = calm ? 0 : $urandom_range(0, 15);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    initial
    begin
        rrg_pkg::req_t directed[$];
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        calm      = 1'b0;

        directed = '{
            fraction(0, 0), fraction(0, 5), fraction(0, -7), fraction(5, 0),
            fraction(-5, 0), fraction(6, 4), fraction(-6, 4), fraction(6, -4),
            fraction(-6, -4), fraction(1, 1), fraction(-1, -1),
            fraction(MOST_POS, MOST_POS), fraction(MOST_POS, MOST_NEG + 1),
            fraction(MOST_NEG, 1), fraction(1, MOST_NEG), fraction(MOST_NEG, MOST_NEG),
            fraction(MOST_NEG, 0), fraction(0, MOST_NEG), fraction(MOST_POS, 1),
            fraction(1, MOST_POS), fraction(1836311903, 1134903170),
            fraction(-1134903170, 1836311903), fraction(2147483647, 2147483629)
        };

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed[i])
            send(directed[i]);
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (i % 250 == 125)
                drain();
            send(draw_fraction());
        end
        req_valid <= 1'b0;

        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("rational_reduce_gcd_tb: done, clean");
        else
            $display("rational_reduce_gcd_tb: done, errors");
        $finish;
    end

endmodule
